// ===== hw/rtl/sglm_pkg.sv =====
// Package for the SiLU table gate multiply block.
// Holds widths, register codes, reset values and the stage structs.
// No dependencies.
package sglm_pkg;

   localparam int MAX_TABLE_BITS = 12;
   localparam int TABLE_DEPTH    = (1 << MAX_TABLE_BITS) + 1;
   localparam int ADDR_W         = $clog2(TABLE_DEPTH);
   localparam int SIZE_W         = MAX_TABLE_BITS + 1;

   localparam int CLAMP_W    = 15;
   localparam int SCALE_W    = 32;
   localparam int BITS_W     = 4;
   localparam int ENTRY_W    = 13;
   localparam int SAMPLE_W   = 16;
   localparam int PRODUCT_W  = 32;
   localparam int FRAC_W     = 16;
   localparam int POS_W      = SAMPLE_W + SCALE_W;   // Q24.24 table position
   localparam int INDEX_LSB  = 24;
   localparam int IDX_RAW_W  = POS_W - INDEX_LSB;
   localparam int FRAC_LSB   = INDEX_LSB - FRAC_W;
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int DPROD_W    = 2 * DIFF_W;
   localparam int INTERP_W   = SAMPLE_W + 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [CLAMP_W-1:0] CLAMP_RESET = CLAMP_W'(1024);
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(33554432);
   localparam logic [BITS_W-1:0]  BITS_RESET  = BITS_W'(12);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CLAMP_LEVEL = 2'd0,
      CSR_INDEX_SCALE = 2'd1,
      CSR_TABLE_BITS  = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } op_type;

   typedef struct packed {
      logic [CLAMP_W-1:0] clamp;
      logic [SCALE_W-1:0] scale;
      logic [BITS_W-1:0]  bits;
   } cfg_type;

   // Evaluate side-band that travels next to the table read.
   typedef struct packed {
      logic                       valid;
      logic [FRAC_W-1:0]          frac;
      logic signed [SAMPLE_W-1:0] up;
   } tap_type;

   typedef struct packed {
      logic                  nonempty;
      logic [FIFO_LVL_W-1:0] level;
   } fifo_stat_type;

   // Interval count 2^bits, bits held to 1..MAX_TABLE_BITS.
   function automatic logic [SIZE_W-1:0] table_size(input logic [BITS_W-1:0] bits);
      logic [BITS_W-1:0] b;
      b = bits;
      if (b == '0) begin
         b = BITS_W'(1);
      end else if (b > BITS_W'(MAX_TABLE_BITS)) begin
         b = BITS_W'(MAX_TABLE_BITS);
      end
      return SIZE_W'(1) << b;
   endfunction

endpackage

// ===== hw/rtl/sglm_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module sglm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4097,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [WIDTH-1:0] rd_data_in;

   always_comb begin
      rd_data_in = '0;
      if (rd_addr < AW'(DEPTH - 1) || rd_addr == AW'(DEPTH - 1)) begin
         rd_data_in = mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= rd_data_in;
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sglm_addr.sv =====
// Front end: clamp test, table position multiply, entry addressing, table writes.
// Depends on sglm_pkg.
module sglm_addr (
   input  logic                                clock,
   input  logic                                reset,
   input  sglm_pkg::cfg_type                   cfg,
   input  logic                                req_take,
   input  logic                                req_operation,
   input  logic [sglm_pkg::ENTRY_W-1:0]        req_entry_index,
   input  logic signed [sglm_pkg::SAMPLE_W-1:0] req_entry_value,
   input  logic signed [sglm_pkg::SAMPLE_W-1:0] req_gate_value,
   input  logic signed [sglm_pkg::SAMPLE_W-1:0] req_up_value,
   output logic                                ram_we,
   output logic [sglm_pkg::ADDR_W-1:0]         ram_waddr,
   output logic [sglm_pkg::SAMPLE_W-1:0]       ram_wdata,
   output logic [sglm_pkg::ADDR_W-1:0]         ram_raddr0,
   output logic [sglm_pkg::ADDR_W-1:0]         ram_raddr1,
   output sglm_pkg::tap_type                   tap
);
   import sglm_pkg::*;

   // stage 1: offset gate and saturation flags
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_op_ff, s1_op_in;
   logic                       s1_lo_ff, s1_lo_in;
   logic                       s1_hi_ff, s1_hi_in;
   logic [SAMPLE_W-1:0]        s1_sum_ff, s1_sum_in;
   logic signed [SAMPLE_W-1:0] s1_up_ff, s1_up_in;
   logic [ENTRY_W-1:0]         s1_widx_ff, s1_widx_in;
   logic [SAMPLE_W-1:0]        s1_wval_ff, s1_wval_in;

   // stage 2: table position
   logic                       s2_valid_ff, s2_valid_in;
   logic                       s2_op_ff, s2_op_in;
   logic                       s2_lo_ff, s2_lo_in;
   logic                       s2_hi_ff, s2_hi_in;
   logic [POS_W-1:0]           s2_pos_ff, s2_pos_in;
   logic signed [SAMPLE_W-1:0] s2_up_ff, s2_up_in;
   logic [ENTRY_W-1:0]         s2_widx_ff, s2_widx_in;
   logic [SAMPLE_W-1:0]        s2_wval_ff, s2_wval_in;

   tap_type tap_ff, tap_in;

   logic signed [SAMPLE_W:0] gate_x, clamp_x, sum_x;
   logic [SIZE_W-1:0]        size, last;
   logic [IDX_RAW_W-1:0]     idx_raw;
   logic [SIZE_W-1:0]        idx;
   logic                     sat;

   always_comb begin
      gate_x  = (SAMPLE_W + 1)'(req_gate_value);
      clamp_x = $signed({2'b00, cfg.clamp});
      sum_x   = gate_x + clamp_x;

      s1_valid_in = req_take;
      s1_op_in    = req_operation;
      s1_lo_in    = (sum_x <= 0);
      s1_hi_in    = (gate_x >= clamp_x);
      s1_sum_in   = sum_x[SAMPLE_W-1:0];
      s1_up_in    = req_up_value;
      s1_widx_in  = req_entry_index;
      s1_wval_in  = req_entry_value;
   end

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_op_in    = s1_op_ff;
      s2_lo_in    = s1_lo_ff;
      s2_hi_in    = s1_hi_ff;
      s2_pos_in   = POS_W'(s1_sum_ff) * POS_W'(cfg.scale);
      s2_up_in    = s1_up_ff;
      s2_widx_in  = s1_widx_ff;
      s2_wval_in  = s1_wval_ff;
   end

   // Writes and reads share this stage in request order, so a read
   // always sees every earlier write.
   always_comb begin
      size    = table_size(cfg.bits);
      last    = size - SIZE_W'(1);
      idx_raw = s2_pos_ff[POS_W-1:INDEX_LSB];
      idx     = (idx_raw > IDX_RAW_W'(last)) ? last : idx_raw[SIZE_W-1:0];
      sat     = s2_lo_ff || s2_hi_ff;

      if (s2_lo_ff) begin
         ram_raddr0 = '0;
      end else if (s2_hi_ff) begin
         ram_raddr0 = ADDR_W'(size);
      end else begin
         ram_raddr0 = ADDR_W'(idx);
      end
      ram_raddr1 = sat ? ram_raddr0 : ADDR_W'(idx + SIZE_W'(1));

      ram_we    = s2_valid_ff && (s2_op_ff == OP_WRITE) && (s2_widx_ff < ENTRY_W'(TABLE_DEPTH));
      ram_waddr = ADDR_W'(s2_widx_ff);
      ram_wdata = s2_wval_ff;

      tap_in.valid = s2_valid_ff && (s2_op_ff == OP_EVAL);
      tap_in.frac  = sat ? '0 : s2_pos_ff[INDEX_LSB-1:FRAC_LSB];
      tap_in.up    = s2_up_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         tap_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         tap_ff.valid <= tap_in.valid;
      end
      s1_op_ff    <= s1_op_in;
      s1_lo_ff    <= s1_lo_in;
      s1_hi_ff    <= s1_hi_in;
      s1_sum_ff   <= s1_sum_in;
      s1_up_ff    <= s1_up_in;
      s1_widx_ff  <= s1_widx_in;
      s1_wval_ff  <= s1_wval_in;
      s2_op_ff    <= s2_op_in;
      s2_lo_ff    <= s2_lo_in;
      s2_hi_ff    <= s2_hi_in;
      s2_pos_ff   <= s2_pos_in;
      s2_up_ff    <= s2_up_in;
      s2_widx_ff  <= s2_widx_in;
      s2_wval_ff  <= s2_wval_in;
      tap_ff.frac <= tap_in.frac;
      tap_ff.up   <= tap_in.up;
   end

   assign tap = tap_ff;

endmodule

// ===== hw/rtl/sglm_interp.sv =====
// Back end: linear interpolation between two samples, then multiply by up.
// Depends on sglm_pkg.
module sglm_interp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sglm_pkg::tap_type                    tap,
   input  logic signed [sglm_pkg::SAMPLE_W-1:0]  y0,
   input  logic signed [sglm_pkg::SAMPLE_W-1:0]  y1,
   output logic                                 push,
   output logic signed [sglm_pkg::PRODUCT_W-1:0] product
);
   import sglm_pkg::*;

   logic                       a_valid_ff, a_valid_in;
   logic signed [DIFF_W-1:0]   a_diff_ff, a_diff_in;
   logic signed [SAMPLE_W-1:0] a_y0_ff, a_y0_in;
   logic [FRAC_W-1:0]          a_frac_ff, a_frac_in;
   logic signed [SAMPLE_W-1:0] a_up_ff, a_up_in;

   logic                       b_valid_ff, b_valid_in;
   logic signed [DPROD_W-1:0]  b_dprod_ff, b_dprod_in;
   logic signed [SAMPLE_W-1:0] b_y0_ff, b_y0_in;
   logic signed [SAMPLE_W-1:0] b_up_ff, b_up_in;

   logic                       c_valid_ff, c_valid_in;
   logic signed [SAMPLE_W-1:0] c_s_ff, c_s_in;
   logic signed [SAMPLE_W-1:0] c_up_ff, c_up_in;

   logic                        push_ff, push_in;
   logic signed [PRODUCT_W-1:0] product_ff, product_in;

   logic signed [INTERP_W-1:0] interp_sum;
   logic                       trunc_fix;

   always_comb begin
      a_valid_in = tap.valid;
      a_diff_in  = DIFF_W'(y1) - DIFF_W'(y0);
      a_y0_in    = y0;
      a_frac_in  = tap.frac;
      a_up_in    = tap.up;

      b_valid_in = a_valid_ff;
      b_dprod_in = DPROD_W'(a_diff_ff) * DPROD_W'($signed({1'b0, a_frac_ff}));
      b_y0_in    = a_y0_ff;
      b_up_in    = a_up_ff;

      // floor shift plus one when negative with dropped bits: truncation to zero
      trunc_fix  = b_dprod_ff[DPROD_W-1] && (b_dprod_ff[FRAC_W-1:0] != '0);
      interp_sum = INTERP_W'(b_y0_ff)
                 + INTERP_W'(b_dprod_ff[DPROD_W-1:FRAC_W])
                 + INTERP_W'({1'b0, trunc_fix});
      c_valid_in = b_valid_ff;
      c_s_in     = interp_sum[SAMPLE_W-1:0];
      c_up_in    = b_up_ff;

      push_in    = c_valid_ff;
      product_in = PRODUCT_W'(c_s_ff) * PRODUCT_W'(c_up_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         push_ff    <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         push_ff    <= push_in;
      end
      a_diff_ff  <= a_diff_in;
      a_y0_ff    <= a_y0_in;
      a_frac_ff  <= a_frac_in;
      a_up_ff    <= a_up_in;
      b_dprod_ff <= b_dprod_in;
      b_y0_ff    <= b_y0_in;
      b_up_ff    <= b_up_in;
      c_s_ff     <= c_s_in;
      c_up_ff    <= c_up_in;
      product_ff <= product_in;
   end

   assign push    = push_ff;
   assign product = product_ff;

endmodule

// ===== hw/rtl/sglm_fifo.sv =====
// Response queue that absorbs in-flight results while the receiver stalls.
// Depends on sglm_pkg.
module sglm_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  logic signed [sglm_pkg::PRODUCT_W-1:0] push_data,
   input  logic                                 pop,
   output logic signed [sglm_pkg::PRODUCT_W-1:0] head_data,
   output sglm_pkg::fifo_stat_type              stat
);
   import sglm_pkg::*;

   logic [PRODUCT_W-1:0]  mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_LVL_W-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff + FIFO_LVL_W'(push) - FIFO_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data     = mem_ff[rd_ptr_ff];
   assign stat.nonempty = (level_ff != '0);
   assign stat.level    = level_ff;

endmodule

// ===== hw/rtl/silu_lut_gate_multiply_top.sv =====
// SwiGLU gate element: SiLU table lookup with linear interpolation times up.
// Instantiates sglm_addr, two sglm_ram copies, sglm_interp, sglm_fifo; uses sglm_pkg.
//
// Usage:
//  - Request channel (req_*): operation 0 writes entry_value into table entry
//    entry_index (indexes past the table are dropped); operation 1 evaluates
//    interp_silu(gate_value) * up_value. Only evaluates produce a response.
//  - Response channel (rsp_*): gated_product in signed Q16.16.
//  - CSR port: clamp_level, index_scale, table_bits; write only while idle.
//  - Throughput: one request per cycle while req_stall is low, set by the two
//    table copies (one read port each, both written by every table write) so
//    both samples are read in the same cycle.
//  - Table writes and reads happen in the same stage in request order, so an
//    evaluate always sees every earlier write; no forwarding is needed.
//  - The table has no reset and no clearing pass; every entry must be written
//    before an evaluate reads it. Reset clears the pipeline, the queue and
//    loads the CSR defaults.
//  - rsp_stall: results collect in a 16-entry queue. A credit counter tracks
//    evaluates accepted but not yet delivered; req_stall rises when it reaches
//    the queue depth, so nothing is ever dropped.
module silu_lut_gate_multiply_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_operation,
   input  logic [sglm_pkg::ENTRY_W-1:0]          req_entry_index,
   input  logic signed [sglm_pkg::SAMPLE_W-1:0]  req_entry_value,
   input  logic signed [sglm_pkg::SAMPLE_W-1:0]  req_gate_value,
   input  logic signed [sglm_pkg::SAMPLE_W-1:0]  req_up_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [sglm_pkg::PRODUCT_W-1:0] rsp_gated_product,
   input  logic                                  csr_write_enable,
   input  logic [sglm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sglm_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import sglm_pkg::*;

   // configuration registers
   logic [CLAMP_W-1:0] clamp_ff, clamp_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [BITS_W-1:0]  bits_ff, bits_in;
   cfg_type            cfg;

   // credit counter: evaluates accepted and not yet delivered
   logic [FIFO_LVL_W-1:0] credit_ff, credit_in;

   logic req_take, eval_take, rsp_take;

   logic                        ram_we;
   logic [ADDR_W-1:0]           ram_waddr, ram_raddr0, ram_raddr1;
   logic [SAMPLE_W-1:0]         ram_wdata, y0, y1;
   tap_type                     tap;
   logic                        push;
   logic signed [PRODUCT_W-1:0] product;
   fifo_stat_type               fifo_stat;

   always_comb begin
      clamp_in = clamp_ff;
      scale_in = scale_ff;
      bits_in  = bits_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CLAMP_LEVEL: clamp_in = csr_write_data[CLAMP_W-1:0];
            CSR_INDEX_SCALE: scale_in = csr_write_data[SCALE_W-1:0];
            CSR_TABLE_BITS:  bits_in  = csr_write_data[BITS_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.clamp = clamp_ff;
   assign cfg.scale = scale_ff;
   assign cfg.bits  = bits_ff;

   // Stall depends only on the credit count, never on req_valid.
   assign req_stall = (credit_ff == FIFO_LVL_W'(FIFO_DEPTH));
   assign req_take  = req_valid && !req_stall;
   assign eval_take = req_take && (req_operation == OP_EVAL);
   assign rsp_take  = rsp_valid && !rsp_stall;

   always_comb begin
      credit_in = credit_ff + FIFO_LVL_W'(eval_take) - FIFO_LVL_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff  <= CLAMP_RESET;
         scale_ff  <= SCALE_RESET;
         bits_ff   <= BITS_RESET;
         credit_ff <= '0;
      end else begin
         clamp_ff  <= clamp_in;
         scale_ff  <= scale_in;
         bits_ff   <= bits_in;
         credit_ff <= credit_in;
      end
   end

   sglm_addr u_addr (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_take        (req_take),
      .req_operation   (req_operation),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_gate_value  (req_gate_value),
      .req_up_value    (req_up_value),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .ram_raddr0      (ram_raddr0),
      .ram_raddr1      (ram_raddr1),
      .tap             (tap)
   );

   // lower sample copy
   sglm_ram #(.WIDTH(SAMPLE_W), .DEPTH(TABLE_DEPTH)) u_ram_lo (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr0),
      .rd_data (y0)
   );

   // upper sample copy, same contents
   sglm_ram #(.WIDTH(SAMPLE_W), .DEPTH(TABLE_DEPTH)) u_ram_hi (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr1),
      .rd_data (y1)
   );

   sglm_interp u_interp (
      .clock   (clock),
      .reset   (reset),
      .tap     (tap),
      .y0      ($signed(y0)),
      .y1      ($signed(y1)),
      .push    (push),
      .product (product)
   );

   sglm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (product),
      .pop       (rsp_take),
      .head_data (rsp_gated_product),
      .stat      (fifo_stat)
   );

   assign rsp_valid = fifo_stat.nonempty;

`ifndef SYNTH
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= FIFO_LVL_W'(FIFO_DEPTH))
      else $error("credit count above queue depth");

   a_queue_within_credit: assert property (@(posedge clock) disable iff (reset)
      fifo_stat.level <= credit_ff)
      else $error("queue holds more results than accepted evaluates");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_stat.level != FIFO_LVL_W'(FIFO_DEPTH)))
      else $error("result pushed into a full queue");

   a_valid_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (credit_ff != '0))
      else $error("response without an outstanding evaluate");
`endif

endmodule

// ===== tb/sv/tb_silu_lut_gate_multiply_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for silu_lut_gate_multiply_top: table load, lookup, interp, multiply.
// Drives requests and CSR writes, predicts every gated product in place.
// Depends on sglm_pkg and the RTL of silu_lut_gate_multiply_top.
module tb_silu_lut_gate_multiply_top;
   import sglm_pkg::*;

   // Drain margin for the queue and any write still in flight.
   localparam int DRAIN_CYCLES    = 16;
   // Cycles with no handshake on either side before the run is declared hung.
   // Random stalls are short geometric runs, so this is far above any correct run.
   localparam int WATCHDOG_LIMIT  = 10000;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int PHASES          = 8;
   localparam int DIRECTED_ROWS   = 20;
   localparam int RANDOM_CFG_PHASE = 6;

   // No register lives at this index; writes there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = CSR_INDEX_W'(3);

   // Idling modes, rotated over the random phases.
   localparam int IDLE_NONE   = 0;
   localparam int IDLE_SEND   = 1;
   localparam int IDLE_RECV   = 2;
   localparam int IDLE_BOTH   = 3;

   typedef struct packed {
      op_type                      op;
      logic [ENTRY_W-1:0]          entry_index;
      logic signed [SAMPLE_W-1:0]  entry_value;
      logic signed [SAMPLE_W-1:0]  gate;
      logic signed [SAMPLE_W-1:0]  up;
      logic                        fixed;          // use fixed_product, not the predictor
      logic signed [PRODUCT_W-1:0] fixed_product;
   } gate_request_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_operation = 1'b0;
   logic [ENTRY_W-1:0]          req_entry_index = '0;
   logic signed [SAMPLE_W-1:0]  req_entry_value = '0;
   logic signed [SAMPLE_W-1:0]  req_gate_value = '0;
   logic signed [SAMPLE_W-1:0]  req_up_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [PRODUCT_W-1:0] rsp_gated_product;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_write_data = '0;

   // Shadow of the block's registers and table, as the predictor sees them.
   logic [CLAMP_W-1:0]          shadow_clamp = CLAMP_RESET;
   logic [SCALE_W-1:0]          shadow_scale = SCALE_RESET;
   logic [BITS_W-1:0]           shadow_bits  = BITS_RESET;
   logic signed [SAMPLE_W-1:0]  silu_samples [TABLE_DEPTH];

   gate_request_type            req_backlog [$];     // requests not yet on the bus
   logic signed [PRODUCT_W-1:0] product_expect [$];  // gated products still owed
   gate_request_type            req_head;
   gate_request_type            fill_req;
   cfg_type                     phase_cfg;
   logic                        bus_fixed = 1'b0;
   logic signed [PRODUCT_W-1:0] bus_fixed_product = '0;
   logic signed [PRODUCT_W-1:0] product_head;
   int                          send_idle_pct = 0;
   int                          recv_stall_pct = 0;
   int                          fail_count = 0;
   int                          quiet_cycles = 0;

   // Directed rows, run with reset register values after the full table fill.
   // Typed-in products come from end entries or entries the rows just wrote.
   gate_request_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_WRITE, 13'd0,    16'h8000, 16'h0000, 16'h0000, 1'b0, 32'sd0},
      '{OP_WRITE, 13'd4096, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 32'sd0},
      // most negative gate and up: entry 0 squared
      '{OP_EVAL,  13'd0,    16'h0000, 16'h8000, 16'h8000, 1'b1, 32'sd1073741824},
      // gate exactly -clamp still takes entry 0
      '{OP_EVAL,  13'd0,    16'h0000, 16'hFC00, 16'h7FFF, 1'b1, -32'sd1073709056},
      '{OP_EVAL,  13'd0,    16'h0000, 16'h7FFF, 16'h7FFF, 1'b1, 32'sd1073676289},
      // gate exactly +clamp takes the last entry
      '{OP_EVAL,  13'd0,    16'h0000, 16'h0400, 16'h8000, 1'b1, -32'sd1073709056},
      '{OP_EVAL,  13'd0,    16'h0000, 16'h0000, 16'h0000, 1'b1, 32'sd0},
      // writes past the table are dropped
      '{OP_WRITE, 13'h1FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'sd0},
      '{OP_WRITE, 13'd4097, 16'h1234, 16'h0000, 16'h0000, 1'b0, 32'sd0},
      '{OP_EVAL,  13'd0,    16'h0000, 16'h7FFF, 16'h0001, 1'b1, 32'sd32767},
      '{OP_WRITE, 13'd2,    16'h7FFF, 16'h0000, 16'h0000, 1'b0, 32'sd0},
      '{OP_EVAL,  13'd0,    16'h0000, 16'hFC01, 16'h0100, 1'b1, 32'sd8388352},
      '{OP_WRITE, 13'd4094, 16'h8000, 16'h0000, 16'h0000, 1'b0, 32'sd0},
      '{OP_EVAL,  13'd0,    16'h0000, 16'h03FF, 16'h8000, 1'b1, 32'sd1073741824},
      '{OP_WRITE, 13'd2048, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'sd0},
      '{OP_EVAL,  13'd0,    16'h0000, 16'h0000, 16'h8000, 1'b1, 32'sd0},
      '{OP_EVAL,  13'd0,    16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 32'sd0},
      '{OP_EVAL,  13'd0,    16'h0000, 16'h0200, 16'h3039, 1'b0, 32'sd0},
      '{OP_EVAL,  13'd0,    16'h0000, 16'h8001, 16'h5A5A, 1'b0, 32'sd0},
      '{OP_EVAL,  13'd0,    16'h0000, 16'h0001, 16'h7FFF, 1'b0, 32'sd0}
   };

   // Register settings per random phase: clamp, scale, table bits.
   cfg_type phase_settings [PHASES] = '{
      '{15'd1024,  32'd33554432, 4'd12},   // defaults, scale matched to clamp
      '{15'd256,   32'd524288,   4'd4},
      '{15'd32767, 32'd1048608,  4'd12},   // widest clamp
      '{15'd1,     32'd16777216, 4'd1},    // narrowest nonzero clamp, smallest table
      '{15'd1000,  32'hFFFFFFFF, 4'd0},    // bits 0 acts as 1; max scale pins index
      '{15'd0,     32'd1,        4'd15},   // zero clamp, bits above the maximum
      '{15'd0,     32'd0,        4'd13},   // clamp and scale drawn at run time
      '{15'd2048,  32'd1048576,  4'd8}
   };

   silu_lut_gate_multiply_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_entry_index   (req_entry_index),
      .req_entry_value   (req_entry_value),
      .req_gate_value    (req_gate_value),
      .req_up_value      (req_up_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_gated_product (rsp_gated_product),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Interval count with table_bits held to 1..MAX_TABLE_BITS.
   function automatic int unsigned table_intervals();
      int unsigned b;
      b = shadow_bits;
      if (b < 1) b = 1;
      if (b > MAX_TABLE_BITS) b = MAX_TABLE_BITS;
      return 1 << b;
   endfunction

   // Interpolated SiLU of gate, times up, as a Q16.16 product.
   function automatic logic signed [PRODUCT_W-1:0] predict_gated_product(
         input logic signed [SAMPLE_W-1:0] gate, input logic signed [SAMPLE_W-1:0] up);
      int unsigned     size;
      int              c;
      int              g;
      longint unsigned pos;
      longint unsigned whole;
      int unsigned     idx;
      longint          frac;
      longint          y0;
      longint          diff;
      longint          part;
      longint          sample;
      longint          product;
      size = table_intervals();
      c = int'(shadow_clamp);
      g = int'(gate);
      if (g <= -c) begin
         sample = silu_samples[0];
      end else if (g >= c) begin
         sample = silu_samples[size];
      end else begin
         // Q8.8 offset times Q16.16 step gives a Q24.24 table position
         pos   = longint'(g + c) * longint'(shadow_scale);
         whole = pos >> 24;
         idx   = (whole > longint'(size - 1)) ? size - 1 : 32'(whole);
         frac  = longint'((pos >> 8) & 64'hFFFF);
         y0    = silu_samples[idx];
         diff  = longint'(silu_samples[idx + 1]) - y0;
         // step toward the next sample truncates toward zero
         part  = ((diff < 0 ? -diff : diff) * frac) >>> 16;
         if (diff < 0) part = -part;
         sample = y0 + part;
      end
      product = sample * longint'(up);
      return product[PRODUCT_W-1:0];
   endfunction

   // Register write; enable is left high so back-to-back writes never toggle it.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] reg_index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= reg_index;
      csr_write_data   <= data;
      case (reg_index)
         CSR_CLAMP_LEVEL: shadow_clamp = data[CLAMP_W-1:0];
         CSR_INDEX_SCALE: shadow_scale = data;
         CSR_TABLE_BITS:  shadow_bits  = data[BITS_W-1:0];
         default: ;
      endcase
   endtask

   // Block is idle once every request is taken, every product is back, and
   // trailing table writes have had time to land.
   task automatic wait_idle();
      while (req_backlog.size() != 0 || req_valid || product_expect.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random requests for the current register setting. Most gates fall
   // inside the clamp so that interpolation is exercised; the rest sit on
   // the clamp edges, the extremes or anywhere. Dropped writes are not counted.
   task automatic queue_random_requests(input int count);
      gate_request_type r;
      int               counted;
      int               sel;
      int               c;
      int               v;
      counted = 0;
      c = int'(shadow_clamp);
      while (counted < count) begin
         r.entry_index   = ENTRY_W'($urandom());
         r.entry_value   = SAMPLE_W'($urandom());
         r.fixed         = 1'b0;
         r.fixed_product = '0;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = (c > 1) ? int'($urandom_range(0, 2 * c - 2)) - c + 1 : 0;
            5: begin
               case ($urandom_range(0, 5))
                  0: v = -c - 1;
                  1: v = -c;
                  2: v = -c + 1;
                  3: v = c - 1;
                  4: v = c;
                  default: v = c + 1;
               endcase
            end
            6: begin
               case ($urandom_range(0, 3))
                  0: v = -32768;
                  1: v = 32767;
                  2: v = 0;
                  default: v = -1;
               endcase
            end
            default: v = int'($signed(SAMPLE_W'($urandom())));
         endcase
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         r.gate = SAMPLE_W'(v);
         case ($urandom_range(0, 19))
            0: r.up = 16'h8000;
            1: r.up = 16'h7FFF;
            2: r.up = 16'h0000;
            default: r.up = SAMPLE_W'($urandom());
         endcase
         if ($urandom_range(0, 3) == 0) begin
            r.op = OP_WRITE;
            // aim most writes at entries this table size can read
            sel = $urandom_range(0, 9);
            if (sel < 5)
               r.entry_index = ENTRY_W'($urandom_range(0, table_intervals()));
            else if (sel < 9)
               r.entry_index = ENTRY_W'($urandom_range(0, TABLE_DEPTH - 1));
            else
               r.entry_index = ENTRY_W'($urandom_range(TABLE_DEPTH, (1 << ENTRY_W) - 1));
         end else begin
            r.op = OP_EVAL;
         end
         if (r.op == OP_EVAL || r.entry_index < TABLE_DEPTH) counted++;
         req_backlog.push_back(r);
      end
   endtask

   // Request driver: a new request goes out only when the bus is empty or the
   // current one was just taken, so a stalled request holds still.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_head = req_backlog.pop_front();
            req_valid         <= 1'b1;
            req_operation     <= req_head.op;
            req_entry_index   <= req_head.entry_index;
            req_entry_value   <= req_head.entry_value;
            req_gate_value    <= req_head.gate;
            req_up_value      <= req_head.up;
            bus_fixed         <= req_head.fixed;
            bus_fixed_product <= req_head.fixed_product;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Monitor: predicts at request accept, checks at response accept.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (req_operation == OP_WRITE) begin
               if (req_entry_index < TABLE_DEPTH) silu_samples[req_entry_index] = req_entry_value;
            end else begin
               product_expect.push_back(bus_fixed ? bus_fixed_product
                                        : predict_gated_product(req_gate_value, req_up_value));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (product_expect.size() == 0) begin
               $error("gated_product: expected no response, actual %0d", rsp_gated_product);
               fail_count++;
            end else begin
               product_head = product_expect.pop_front();
               if (rsp_gated_product !== product_head) begin
                  $error("gated_product: expected %0d, actual %0d",
                         product_head, rsp_gated_product);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb_silu_lut_gate_multiply_top NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The table has no reset: fill every entry before anything reads it.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         fill_req.op            = OP_WRITE;
         fill_req.entry_index   = ENTRY_W'(i);
         fill_req.entry_value   = SAMPLE_W'($urandom());
         fill_req.gate          = SAMPLE_W'($urandom());
         fill_req.up            = SAMPLE_W'($urandom());
         fill_req.fixed         = 1'b0;
         fill_req.fixed_product = '0;
         req_backlog.push_back(fill_req);
      end
      foreach (directed_rows[k]) req_backlog.push_back(directed_rows[k]);
      wait_idle();

      for (int ph = 0; ph < PHASES; ph++) begin
         phase_cfg = phase_settings[ph];
         if (ph == RANDOM_CFG_PHASE) begin
            phase_cfg.clamp = CLAMP_W'($urandom_range(1, 32767));
            phase_cfg.scale = SCALE_W'($urandom_range(1, 32'h0400_0000));
         end
         // junk in the unused upper bits must be ignored
         write_register(CSR_CLAMP_LEVEL, {17'($urandom()), phase_cfg.clamp});
         write_register(CSR_INDEX_SCALE, phase_cfg.scale);
         write_register(CSR_TABLE_BITS, {28'($urandom()), phase_cfg.bits});
         if (ph == 1) write_register(CSR_UNMAPPED, $urandom());
         @(posedge clock);
         csr_write_enable <= 1'b0;

         case (ph % 4)
            IDLE_NONE: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            IDLE_SEND: begin
               send_idle_pct  = 47;
               recv_stall_pct = 0;
            end
            IDLE_RECV: begin
               send_idle_pct  = 0;
               recv_stall_pct = 47;
            end
            default: begin
               send_idle_pct  = 35;
               recv_stall_pct = 35;
            end
         endcase
         queue_random_requests(ITEMS_PER_PHASE);
         wait_idle();
      end

      if (fail_count == 0 && product_expect.size() == 0) begin
         $display("tb_silu_lut_gate_multiply_top OK");
      end else begin
         $display("tb_silu_lut_gate_multiply_top NOT OK");
      end
      $finish;
   end

endmodule

// ===== silu_lut_gate_multiply_top.f =====
hw/rtl/sglm_pkg.sv
hw/rtl/sglm_ram.sv
hw/rtl/sglm_addr.sv
hw/rtl/sglm_interp.sv
hw/rtl/sglm_fifo.sv
hw/rtl/silu_lut_gate_multiply_top.sv
tb/sv/tb_silu_lut_gate_multiply_top.sv
